[design/mfl_pkg.sv]
// shared types, constants and lookup tables of the multiplex frame length calculator
`default_nettype none

package mfl_pkg;

   localparam int LEVELS    = 5;
   localparam int CELL_W    = 13;
   localparam int NUM_W     = 4;
   localparam int BYTES_W   = 12;
   localparam int LCM_W     = 8;
   localparam int PLCM_W    = 9;
   localparam int GRP_W     = 16;
   localparam int SPACE_W   = CELL_W + 1;
   localparam int NET_W     = 17;
   localparam int LEN_W     = 11;
   localparam int TAIL_BITS = 12;
   localparam int OCC_COUNT = 6;

   // function codes
   localparam logic FUNC_SPP  = 1'b0;
   localparam logic FUNC_VSPP = 1'b1;

   // constellation codes
   localparam logic [1:0] CON_SM     = 2'd0;
   localparam logic [1:0] CON_HM_MIX = 2'd1;
   localparam logic [1:0] CON_HM_SYM = 2'd2;
   localparam logic [1:0] CON_QAM16  = 2'd3;

   typedef logic [LEVELS-1:0][NUM_W-1:0] lvl_vec_type;

   // cells per frame, zero where the mode and occupancy do not combine
   localparam logic [CELL_W-1:0] CELL_ROM [4][OCC_COUNT] = '{
      '{13'd1259, 13'd1422, 13'd2632, 13'd2959, 13'd5464, 13'd6118},
      '{13'd966,  13'd1110, 13'd2051, 13'd2337, 13'd4249, 13'd4774},
      '{13'd0,    13'd0,    13'd0,    13'd1844, 13'd0,    13'd3867},
      '{13'd0,    13'd0,    13'd0,    13'd1226, 13'd0,    13'd2606}
   };

   // per level code rate numerators, [constellation][rate][level]
   localparam logic [NUM_W-1:0] NUM_ROM [4][4][LEVELS] = '{
      '{'{4'd1,4'd1,4'd3,4'd0,4'd0}, '{4'd1,4'd2,4'd4,4'd0,4'd0},
        '{4'd1,4'd3,4'd7,4'd0,4'd0}, '{4'd2,4'd4,4'd8,4'd0,4'd0}},
      '{'{4'd1,4'd3,4'd1,4'd3,4'd3}, '{4'd1,4'd4,4'd2,4'd8,4'd4},
        '{4'd1,4'd4,4'd3,4'd7,4'd7}, '{4'd2,4'd2,4'd4,4'd8,4'd8}},
      '{'{4'd3,4'd3,4'd0,4'd0,4'd0}, '{4'd4,4'd8,4'd0,4'd0,4'd0},
        '{4'd4,4'd7,4'd0,4'd0,4'd0}, '{4'd2,4'd8,4'd0,4'd0,4'd0}},
      '{'{4'd1,4'd2,4'd0,4'd0,4'd0}, '{4'd1,4'd3,4'd0,4'd0,4'd0},
        '{4'd0,4'd0,4'd0,4'd0,4'd0}, '{4'd0,4'd0,4'd0,4'd0,4'd0}}
   };

   // per level code rate denominators
   localparam logic [NUM_W-1:0] DEN_ROM [4][4][LEVELS] = '{
      '{'{4'd4,4'd2,4'd4,4'd1,4'd1}, '{4'd3,4'd3,4'd5,4'd1,4'd1},
        '{4'd2,4'd4,4'd8,4'd1,4'd1}, '{4'd3,4'd5,4'd9,4'd1,4'd1}},
      '{'{4'd4,4'd10,4'd2,4'd5,4'd4}, '{4'd3,4'd11,4'd3,4'd11,4'd5},
        '{4'd2,4'd7,4'd4,4'd8,4'd8}, '{4'd3,4'd3,4'd5,4'd9,4'd9}},
      '{'{4'd10,4'd5,4'd1,4'd1,4'd1}, '{4'd11,4'd11,4'd1,4'd1,4'd1},
        '{4'd7,4'd8,4'd1,4'd1,4'd1}, '{4'd3,4'd9,4'd1,4'd1,4'd1}},
      '{'{4'd3,4'd3,4'd1,4'd1,4'd1}, '{4'd2,4'd4,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1}, '{4'd1,4'd1,4'd1,4'd1,4'd1}}
   };

   localparam logic [LCM_W-1:0] LCM_ROM [4][4] = '{
      '{8'd4,  8'd15,  8'd8,  8'd45},
      '{8'd20, 8'd165, 8'd56, 8'd45},
      '{8'd10, 8'd11,  8'd56, 8'd9},
      '{8'd3,  8'd4,   8'd1,  8'd1}
   };

   // net bits of one lcm group of cells, gross bits per cell included
   localparam logic [PLCM_W-1:0] PLCM_ROM [4][4] = '{
      '{9'd12, 9'd54,  9'd34,  9'd212},
      '{9'd48, 9'd477, 9'd200, 9'd176},
      '{9'd18, 9'd24,  9'd162, 9'd28},
      '{9'd6,  9'd10,  9'd0,   9'd0}
   };

   localparam logic RATE_OK_ROM [4][4] = '{
      '{1'b1, 1'b1, 1'b1, 1'b1},
      '{1'b1, 1'b1, 1'b1, 1'b1},
      '{1'b1, 1'b1, 1'b1, 1'b1},
      '{1'b1, 1'b1, 1'b0, 1'b0}
   };

   // set where the constellation carries two gross bits per cell
   localparam logic GROSS2_ROM [4] = '{1'b1, 1'b0, 1'b1, 1'b1};

   localparam logic [NUM_W-1:0] VS_NUM [4] = '{4'd1, 4'd4, 4'd3, 4'd2};
   localparam logic [NUM_W-1:0] VS_DEN [4] = '{4'd2, 4'd7, 4'd5, 4'd3};

   // classified transaction, front to back
   typedef struct packed {
      logic                kill;
      logic                zero;
      logic                grp_skip;
      logic [GRP_W-1:0]    grp_num;
      logic [PLCM_W-1:0]   grp_den;
      logic [CELL_W-1:0]   cells;
      logic [LCM_W-1:0]    lcm;
      logic                gross2;
      logic [BYTES_W-1:0]  bytes;
      lvl_vec_type         num_a;
      lvl_vec_type         den_a;
      lvl_vec_type         num_b;
      lvl_vec_type         den_b;
   } mfl_item_type;

   // what the back end keeps beside the level divisions
   typedef struct packed {
      logic                kill;
      logic                zero;
      logic                fail;
      logic [BYTES_W-1:0]  bytes;
      lvl_vec_type         num_a;
      lvl_vec_type         num_b;
   } mfl_mid_type;

endpackage

`default_nettype wire

[design/mfl_front.sv]
// front end: table lookups and classification of one transaction
`default_nettype none

module mfl_front (
   input  wire logic                        req_func,
   input  wire logic [1:0]                  req_robust_mode,
   input  wire logic [2:0]                  req_spec_occupancy,
   input  wire logic [1:0]                  req_constellation_sel,
   input  wire logic [1:0]                  req_rate_a,
   input  wire logic [1:0]                  req_rate_b,
   input  wire logic [1:0]                  req_rate_hier,
   input  wire logic [mfl_pkg::BYTES_W-1:0] req_bytes_a,
   output mfl_pkg::mfl_item_type            item
);

   logic [mfl_pkg::CELL_W-1:0]  cells;
   logic [mfl_pkg::PLCM_W-1:0]  plcm;
   logic [mfl_pkg::BYTES_W-1:0] bytes;
   logic                        rates_ok;

   always_comb begin
      cells = '0;
      if (req_spec_occupancy < 3'(mfl_pkg::OCC_COUNT)) begin
         cells = mfl_pkg::CELL_ROM[req_robust_mode][req_spec_occupancy];
      end
      rates_ok = mfl_pkg::RATE_OK_ROM[req_constellation_sel][req_rate_a]
               & mfl_pkg::RATE_OK_ROM[req_constellation_sel][req_rate_b];

      item.cells  = cells;
      item.gross2 = mfl_pkg::GROSS2_ROM[req_constellation_sel];
      item.zero   = (req_func == mfl_pkg::FUNC_VSPP)
                  && (req_constellation_sel == mfl_pkg::CON_SM
                      || req_constellation_sel == mfl_pkg::CON_QAM16);
      item.kill   = (cells == '0) || (req_func == mfl_pkg::FUNC_SPP && !rates_ok);

      if (req_func == mfl_pkg::FUNC_SPP) begin
         for (int l = 0; l < mfl_pkg::LEVELS; l++) begin
            item.num_a[l] = mfl_pkg::NUM_ROM[req_constellation_sel][req_rate_a][l];
            item.den_a[l] = mfl_pkg::DEN_ROM[req_constellation_sel][req_rate_a][l];
            item.num_b[l] = mfl_pkg::NUM_ROM[req_constellation_sel][req_rate_b][l];
            item.den_b[l] = mfl_pkg::DEN_ROM[req_constellation_sel][req_rate_b][l];
         end
         item.lcm = mfl_pkg::LCM_ROM[req_constellation_sel][req_rate_a];
         plcm     = mfl_pkg::PLCM_ROM[req_constellation_sel][req_rate_a];
         bytes    = req_bytes_a;
      end else begin
         // single level, no part a
         for (int l = 0; l < mfl_pkg::LEVELS; l++) begin
            item.num_a[l] = '0;
            item.den_a[l] = mfl_pkg::NUM_W'(1);
            item.num_b[l] = '0;
            item.den_b[l] = mfl_pkg::NUM_W'(1);
         end
         item.num_a[0] = mfl_pkg::VS_NUM[req_rate_hier];
         item.den_a[0] = mfl_pkg::VS_DEN[req_rate_hier];
         item.num_b[0] = mfl_pkg::VS_NUM[req_rate_hier];
         item.den_b[0] = mfl_pkg::VS_DEN[req_rate_hier];
         item.lcm      = mfl_pkg::LCM_W'(1);
         plcm          = '0;
         bytes         = '0;
      end

      item.bytes    = bytes;
      item.grp_skip = (bytes == '0) || (plcm == '0);
      item.grp_den  = plcm;
      // ceiling of 8 * bytes over the group size
      item.grp_num  = {1'b0, bytes, 3'b000} + mfl_pkg::GRP_W'(plcm) - mfl_pkg::GRP_W'(1);
   end

endmodule

`default_nettype wire

[design/mfl_queue.sv]
// short transaction queue between front and back end
`default_nettype none

module mfl_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  mfl_pkg::mfl_item_type      push_item,
   output logic                       full,
   output logic                       head_valid,
   output mfl_pkg::mfl_item_type      head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mfl_pkg::mfl_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pop;

   // the back end never stalls, so the head leaves whenever present
   assign pop        = (count_ff != '0);
   assign head_valid = pop;
   assign head_item  = mem_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue fill count did not rise on push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      !push && pop |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue fill count did not fall on pop");

endmodule

`default_nettype wire

[design/mfl_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, several lanes
`default_nettype none

module mfl_div_pipe #(
   parameter int W_N   = 16,
   parameter int W_D   = 9,
   parameter int LANES = 1,
   parameter int W_P   = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [LANES-1:0][W_N-1:0]   in_num,
   input  wire logic [LANES-1:0][W_D-1:0]   in_den,
   input  wire logic [W_P-1:0]              in_side,
   output logic                             out_valid,
   output logic [LANES-1:0][W_N-1:0]        out_quo,
   output logic [W_P-1:0]                   out_side
);

   logic [W_N:0]                 vld_ff, vld_in;
   logic [LANES-1:0][W_D-1:0]    rem_ff  [W_N+1];
   logic [LANES-1:0][W_D-1:0]    rem_in  [W_N+1];
   logic [LANES-1:0][W_N-1:0]    num_ff  [W_N+1];
   logic [LANES-1:0][W_N-1:0]    num_in  [W_N+1];
   logic [LANES-1:0][W_N-1:0]    quo_ff  [W_N+1];
   logic [LANES-1:0][W_N-1:0]    quo_in  [W_N+1];
   logic [LANES-1:0][W_D-1:0]    den_ff  [W_N+1];
   logic [LANES-1:0][W_D-1:0]    den_in  [W_N+1];
   logic [W_P-1:0]               side_ff [W_N+1];
   logic [W_P-1:0]               side_in [W_N+1];

   always_comb begin
      logic [W_D:0] trial;
      logic         qbit;
      vld_in[0]  = in_valid;
      rem_in[0]  = '0;
      num_in[0]  = in_num;
      quo_in[0]  = '0;
      den_in[0]  = in_den;
      side_in[0] = in_side;
      for (int s = 1; s <= W_N; s++) begin
         vld_in[s]  = vld_ff[s-1];
         den_in[s]  = den_ff[s-1];
         side_in[s] = side_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            // bring down the next dividend bit, subtract where it fits
            trial = {rem_ff[s-1][l], num_ff[s-1][l][W_N-1]};
            if (trial >= {1'b0, den_ff[s-1][l]}) begin
               rem_in[s][l] = W_D'(trial - {1'b0, den_ff[s-1][l]});
               qbit         = 1'b1;
            end else begin
               rem_in[s][l] = trial[W_D-1:0];
               qbit         = 1'b0;
            end
            num_in[s][l] = {num_ff[s-1][l][W_N-2:0], 1'b0};
            quo_in[s][l] = {quo_ff[s-1][l][W_N-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      side_ff <= side_in;
   end

   assign out_valid = vld_ff[W_N];
   assign out_quo   = quo_ff[W_N];
   assign out_side  = side_ff[W_N];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, W_N + 1))
      else $error("divider result without matching operand");

endmodule

`default_nettype wire

[design/mfl_back.sv]
// back end: group count, part sizes, per level net bits and final length
`default_nettype none

module mfl_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  mfl_pkg::mfl_item_type           in_item,
   output logic                            out_valid,
   output logic [mfl_pkg::LEN_W-1:0]       out_frame_bytes,
   output logic                            out_error_flag
);

   localparam int ITEM_W = $bits(mfl_pkg::mfl_item_type);
   localparam int MID_W  = $bits(mfl_pkg::mfl_mid_type);
   localparam int LANES2 = 2 * mfl_pkg::LEVELS;
   localparam int PROD_W = mfl_pkg::GRP_W + mfl_pkg::LCM_W;

   // group count divider
   logic [0:0][mfl_pkg::GRP_W-1:0]  grp_num;
   logic [0:0][mfl_pkg::PLCM_W-1:0] grp_den;
   logic                            grp_valid;
   logic [0:0][mfl_pkg::GRP_W-1:0]  grp_quo;
   logic [ITEM_W-1:0]               grp_side;
   mfl_pkg::mfl_item_type           it;

   always_comb begin
      grp_num[0] = in_item.grp_skip ? '0 : in_item.grp_num;
      grp_den[0] = in_item.grp_skip ? mfl_pkg::PLCM_W'(1) : in_item.grp_den;
   end

   mfl_div_pipe #(
      .W_N   (mfl_pkg::GRP_W),
      .W_D   (mfl_pkg::PLCM_W),
      .LANES (1),
      .W_P   (ITEM_W)
   ) u_grp_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_num    (grp_num),
      .in_den    (grp_den),
      .in_side   (in_item),
      .out_valid (grp_valid),
      .out_quo   (grp_quo),
      .out_side  (grp_side)
   );

   // part sizes
   logic [PROD_W-1:0]                      cells_a;
   logic [mfl_pkg::CELL_W-1:0]             cells_b;
   logic [mfl_pkg::SPACE_W-1:0]            bits_b;
   logic [mfl_pkg::SPACE_W-1:0]            space_b;
   logic [mfl_pkg::SPACE_W-1:0]            bits_a;
   logic                                   fail;
   logic [LANES2-1:0][mfl_pkg::SPACE_W-1:0] lvl_num;
   logic [LANES2-1:0][mfl_pkg::NUM_W-1:0]   lvl_den;
   mfl_pkg::mfl_mid_type                   mid;

   always_comb begin
      it      = grp_side;
      cells_a = PROD_W'(grp_quo[0]) * PROD_W'(it.lcm);
      cells_b = it.cells - cells_a[mfl_pkg::CELL_W-1:0];
      bits_b  = it.gross2 ? {cells_b, 1'b0} : {1'b0, cells_b};
      bits_a  = it.gross2 ? {cells_a[mfl_pkg::CELL_W-1:0], 1'b0}
                          : {1'b0, cells_a[mfl_pkg::CELL_W-1:0]};
      // part a beyond the frame, or part b short of the tail bits
      fail    = (cells_a > PROD_W'(it.cells))
             || (bits_b < mfl_pkg::SPACE_W'(mfl_pkg::TAIL_BITS));
      space_b = bits_b - mfl_pkg::SPACE_W'(mfl_pkg::TAIL_BITS);
      for (int l = 0; l < mfl_pkg::LEVELS; l++) begin
         lvl_num[l]                   = fail ? '0 : bits_a;
         lvl_den[l]                   = it.den_a[l];
         lvl_num[mfl_pkg::LEVELS + l] = fail ? '0 : space_b;
         lvl_den[mfl_pkg::LEVELS + l] = it.den_b[l];
      end
      mid.kill  = it.kill;
      mid.zero  = it.zero;
      mid.fail  = fail;
      mid.bytes = it.bytes;
      mid.num_a = it.num_a;
      mid.num_b = it.num_b;
   end

   // per level divisions
   logic                                    lvl_valid;
   logic [LANES2-1:0][mfl_pkg::SPACE_W-1:0] lvl_quo;
   logic [MID_W-1:0]                        lvl_side;

   mfl_div_pipe #(
      .W_N   (mfl_pkg::SPACE_W),
      .W_D   (mfl_pkg::NUM_W),
      .LANES (LANES2),
      .W_P   (MID_W)
   ) u_lvl_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (grp_valid),
      .in_num    (lvl_num),
      .in_den    (lvl_den),
      .in_side   (mid),
      .out_valid (lvl_valid),
      .out_quo   (lvl_quo),
      .out_side  (lvl_side)
   );

   // net bits per part
   mfl_pkg::mfl_mid_type        lm;
   logic [mfl_pkg::NET_W-1:0]   sum_a_in, sum_b_in;
   logic [mfl_pkg::NET_W-1:0]   sum_a_ff, sum_b_ff;
   logic                        vld_sum_ff;
   mfl_pkg::mfl_mid_type        mid_sum_ff;

   always_comb begin
      lm       = lvl_side;
      sum_a_in = '0;
      sum_b_in = '0;
      for (int l = 0; l < mfl_pkg::LEVELS; l++) begin
         sum_a_in = sum_a_in + mfl_pkg::NET_W'(mfl_pkg::NET_W'(lvl_quo[l])
                                              * mfl_pkg::NET_W'(lm.num_a[l]));
         sum_b_in = sum_b_in
                  + mfl_pkg::NET_W'(mfl_pkg::NET_W'(lvl_quo[mfl_pkg::LEVELS + l])
                                    * mfl_pkg::NET_W'(lm.num_b[l]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_sum_ff <= 1'b0;
      end else begin
         vld_sum_ff <= lvl_valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_a_ff   <= sum_a_in;
      sum_b_ff   <= sum_b_in;
      mid_sum_ff <= lm;
   end

   // final check and result register
   logic [mfl_pkg::NET_W-1:0]   net;
   logic [mfl_pkg::NET_W-1:0]   need;
   logic                        calc_ok;
   logic                        ok;
   logic                        out_valid_ff;
   logic [mfl_pkg::LEN_W-1:0]   frame_bytes_ff, frame_bytes_in;
   logic                        error_flag_ff, error_flag_in;

   always_comb begin
      net     = sum_a_ff + sum_b_ff;
      need    = mfl_pkg::NET_W'({mid_sum_ff.bytes, 3'b000});
      // length must also fit the result field
      calc_ok = !mid_sum_ff.fail && (net >= need)
             && (net[mfl_pkg::NET_W-1:mfl_pkg::LEN_W+3] == '0);
      ok      = !mid_sum_ff.kill && (mid_sum_ff.zero || calc_ok);
      error_flag_in  = !ok;
      frame_bytes_in = (ok && !mid_sum_ff.zero) ? net[mfl_pkg::LEN_W+2:3] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      frame_bytes_ff <= frame_bytes_in;
      error_flag_ff  <= error_flag_in;
   end

   assign out_valid       = out_valid_ff;
   assign out_frame_bytes = frame_bytes_ff;
   assign out_error_flag  = error_flag_ff;

endmodule

`default_nettype wire

[design/msc_frame_length_calc.sv]
// top level of the multiplex frame length calculator
//
//  channel   ports                              handshake
//  request   start, busy, req_*                 taken when start high and busy low
//  response  rsp_valid, rsp_frame_bytes,        one cycle strobe, cannot be held off
//            rsp_error_flag
//
// one transaction per clock cycle sustained while busy is low; the path from the
// taking edge to the response strobe runs through the queue and the two bit-serial
// divider pipelines (16 stages for the group count, 14 for the per level divisions)
// reset is synchronous and clears the queue and all stage valid bits
// busy rises only when the queue between front and back is full; the back end
// drains one transaction a cycle and the receiver never stalls it
`default_nettype none

module msc_frame_length_calc #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_func,
   input  wire logic [1:0]                  req_robust_mode,
   input  wire logic [2:0]                  req_spec_occupancy,
   input  wire logic [1:0]                  req_constellation_sel,
   input  wire logic [1:0]                  req_rate_a,
   input  wire logic [1:0]                  req_rate_b,
   input  wire logic [1:0]                  req_rate_hier,
   input  wire logic [mfl_pkg::BYTES_W-1:0] req_bytes_a,
   output logic                             rsp_valid,
   output logic [mfl_pkg::LEN_W-1:0]        rsp_frame_bytes,
   output logic                             rsp_error_flag
);

   mfl_pkg::mfl_item_type front_item;
   mfl_pkg::mfl_item_type head_item;
   logic                  head_valid;
   logic                  q_full;
   logic                  accept;

   // table lookups and classification of the incoming transaction
   mfl_front u_front (
      .req_func              (req_func),
      .req_robust_mode       (req_robust_mode),
      .req_spec_occupancy    (req_spec_occupancy),
      .req_constellation_sel (req_constellation_sel),
      .req_rate_a            (req_rate_a),
      .req_rate_b            (req_rate_b),
      .req_rate_hier         (req_rate_hier),
      .req_bytes_a           (req_bytes_a),
      .item                  (front_item)
   );

   assign busy   = q_full;
   assign accept = start && !q_full;

   // decouples the front from the arithmetic pipeline
   mfl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (front_item),
      .full       (q_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // group count, part sizes, level divisions, final length
   mfl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (head_valid),
      .in_item         (head_item),
      .out_valid       (rsp_valid),
      .out_frame_bytes (rsp_frame_bytes),
      .out_error_flag  (rsp_error_flag)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_frame_bytes == '0)
      else $error("error response with non-zero length");

   a_busy_no_push: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept)
      else $error("transaction taken while queue full");

   a_vspp_zero: assert property (@(posedge clock) disable iff (reset)
      accept && front_item.zero |-> !front_item.grp_skip == 1'b0)
      else $error("very strong protection transaction not marked for zero groups");

endmodule

`default_nettype wire
